/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("Next-cycle assertion failed.");

`endif

/* rtl/fcr_pkg.sv */
package fcr_pkg;

	localparam int MAX_CHUNKS_DEF      = 64;
	localparam int MAX_CHUNK_BYTES_DEF = 2048;

	localparam int IN_DATA_W  = 160;
	localparam int OUT_DATA_W = 168;
	localparam int TOTAL_W    = 18;

	localparam logic [1:0] REQ_HEADER = 2'd0;
	localparam logic [1:0] REQ_CHUNK  = 2'd1;
	localparam logic [1:0] REQ_SCAN   = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

/* rtl/frame_chunk_reassembly.sv */
// Channel  Direction  Signals                         Content
// s        in         s_tvalid s_tready s_tdata       one request (header, chunk byte,
//                     s_tuser s_tlast                 missing-chunk search, frame read)
// m        out        m_tvalid m_tready m_tdata       one result per request
//                     m_tlast
//
// A header goes straight to its result; a chunk byte first reads the chunk length memory
// and then writes it back. A search examines the chunks one per cycle, and when no chunk
// is missing it ends with a final check past the last chunk. A read checks the chunk that
// holds the byte before and after the fetch (each check an RLEN and an RCHK step), fetches
// the byte, and ends with an end check when no chunk is left.
// No clearing pass after reset. A new request is taken while a result still waits in the
// output register; the block stalls in its last step only if that register is still full.
module frame_chunk_reassembly #(
	parameter int MAX_CHUNKS      = fcr_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_CHUNK_BYTES = fcr_pkg::MAX_CHUNK_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// hdr_frame_id, hdr_chunk_count, hdr_points, hdr_crc, chunk_index, byte_present,
	// data_byte, scan_start, zero fill
	input  logic [fcr_pkg::IN_DATA_W-1:0] s_tdata,
	// req_type
	input  logic [1:0]                    s_tuser,
	// chunk_end
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// accepted, frame_ready, all_received, byte_total, missing_found, missing_index,
	// read_valid, read_byte, cur_frame_id, cur_points, cur_crc, zero fill
	output logic [fcr_pkg::OUT_DATA_W-1:0] m_tdata,
	// read_final
	output logic                          m_tlast
);

	localparam int CW = $clog2(MAX_CHUNKS + 1);
	localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int LW = $clog2(MAX_CHUNK_BYTES + 1);
	localparam int DEPTH = MAX_CHUNKS * MAX_CHUNK_BYTES;
	localparam int AW = $clog2(DEPTH);
	localparam int TW = fcr_pkg::TOTAL_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHUNK = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_RLEN  = 3'd3;
	localparam logic [2:0] ST_RCHK  = 3'd4;
	localparam logic [2:0] ST_RDATA = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]            state_q;
	logic                  set_up_q;
	logic [63:0]           fid_q;
	logic [CW-1:0]         count_q;
	logic [31:0]           points_q;
	logic [31:0]           crc_q;
	logic [MAX_CHUNKS-1:0] map_q;
	logic [MAX_CHUNKS-1:0] len_vld_q;
	logic [CW-1:0]         recv_cnt_q;
	logic [TW-1:0]         bytes_q;
	logic [CW-1:0]         rc_q;
	logic [LW-1:0]         ro_q;
	logic                  phase_q;
	logic [CW-1:0]         sc_q;

	logic [5:0]            idx_q;
	logic                  present_q;
	logic [7:0]            byte_q;
	logic                  end_q;

	logic                  r_acc_q;
	logic                  r_mf_q;
	logic [5:0]            r_mi_q;
	logic                  r_rv_q;
	logic [7:0]            r_rb_q;
	logic                  r_rf_q;

	logic                  m_tvalid_q;
	logic [fcr_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tlast_q;

	logic [LW-1:0]         len_mem [MAX_CHUNKS];
	logic [LW-1:0]         len_rdata_s1;
	logic                  len_hit_s1;
	logic [7:0]            store_mem [DEPTH];
	logic [7:0]            store_rdata_s1;

	logic [IW-1:0]         len_raddr;
	logic [LW-1:0]         len_cur;
	logic [IW-1:0]         idx_w;
	logic [IW-1:0]         rc_w;
	logic [IW-1:0]         sc_w;
	logic                  idx_ok;
	logic                  chunk_take;
	logic                  len_we;
	logic [LW-1:0]         len_new;
	logic                  store_we;
	logic [AW-1:0]         store_waddr;
	logic [AW-1:0]         store_raddr;
	logic [TW:0]           bytes_sum;
	logic                  out_free;
	logic                  all_rcv;
	logic [6:0]            hdr_cnt;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign idx_w = IW'(idx_q);
	assign rc_w = IW'(rc_q);
	assign sc_w = IW'(sc_q);
	assign hdr_cnt = s_tdata[70:64];
	assign len_raddr = (state_q == ST_IDLE) ? IW'(s_tdata[140:135]) : rc_w;
	assign len_cur = len_hit_s1 ? len_rdata_s1 : '0;
	assign idx_ok = set_up_q && (32'(idx_q) < 32'(count_q));
	assign chunk_take = idx_ok && !map_q[idx_w]
		&& !(present_q && (32'(len_cur) >= 32'(MAX_CHUNK_BYTES)));
	assign len_new = present_q ? len_cur + LW'(1) : len_cur;
	assign len_we = (state_q == ST_CHUNK) && chunk_take && present_q;
	assign store_we = len_we;
	assign store_waddr = AW'(idx_w) * AW'(MAX_CHUNK_BYTES) + AW'(len_cur);
	assign store_raddr = AW'(rc_w) * AW'(MAX_CHUNK_BYTES) + AW'(ro_q);
	assign bytes_sum = {1'b0, bytes_q} + (TW + 1)'(len_new);
	assign all_rcv = set_up_q && (recv_cnt_q == count_q);

	always_ff @(posedge clk) begin
		len_rdata_s1 <= len_mem[len_raddr];
		len_hit_s1 <= len_vld_q[len_raddr];
		if (len_we) begin
			len_mem[idx_w] <= len_new;
		end
	end

	always_ff @(posedge clk) begin
		store_rdata_s1 <= store_mem[store_raddr];
		if (store_we) begin
			store_mem[store_waddr] <= byte_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			idx_q <= s_tdata[140:135];
			present_q <= s_tdata[141];
			byte_q <= s_tdata[149:142];
			end_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			set_up_q <= 1'b0;
			fid_q <= '0;
			count_q <= '0;
			points_q <= '0;
			crc_q <= '0;
			map_q <= '0;
			len_vld_q <= '0;
			recv_cnt_q <= '0;
			bytes_q <= '0;
			rc_q <= '0;
			ro_q <= '0;
			phase_q <= 1'b0;
			sc_q <= '0;
			r_acc_q <= 1'b0;
			r_mf_q <= 1'b0;
			r_mi_q <= '0;
			r_rv_q <= 1'b0;
			r_rb_q <= '0;
			r_rf_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tlast_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						r_acc_q <= (s_tuser == fcr_pkg::REQ_HEADER);
						r_mf_q <= 1'b0;
						r_mi_q <= '0;
						r_rv_q <= 1'b0;
						r_rb_q <= '0;
						r_rf_q <= 1'b0;
						unique case (s_tuser)
							fcr_pkg::REQ_HEADER: begin
								set_up_q <= 1'b1;
								fid_q <= s_tdata[63:0];
								count_q <= (32'(hdr_cnt) > 32'(MAX_CHUNKS))
									? CW'(MAX_CHUNKS) : CW'(hdr_cnt);
								points_q <= s_tdata[102:71];
								crc_q <= s_tdata[134:103];
								map_q <= '0;
								len_vld_q <= '0;
								recv_cnt_q <= '0;
								bytes_q <= '0;
								rc_q <= '0;
								ro_q <= '0;
								state_q <= ST_DONE;
							end
							fcr_pkg::REQ_CHUNK: begin
								state_q <= ST_CHUNK;
							end
							fcr_pkg::REQ_SCAN: begin
								sc_q <= CW'(s_tdata[155:150]);
								state_q <= ST_SCAN;
							end
							fcr_pkg::REQ_READ: begin
								phase_q <= 1'b0;
								state_q <= set_up_q ? ST_RLEN : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CHUNK: begin
					r_acc_q <= idx_ok && (map_q[idx_w] || chunk_take);
					if (len_we) begin
						len_vld_q[idx_w] <= 1'b1;
					end
					if (chunk_take && end_q) begin
						map_q[idx_w] <= 1'b1;
						recv_cnt_q <= recv_cnt_q + CW'(1);
						bytes_q <= bytes_sum[TW] ? fcr_pkg::TOTAL_MAX : bytes_sum[TW-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (set_up_q && (sc_q < count_q)) begin
						if (!map_q[sc_w]) begin
							r_mf_q <= 1'b1;
							r_mi_q <= 6'(sc_q);
							state_q <= ST_DONE;
						end else begin
							sc_q <= sc_q + CW'(1);
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RLEN: begin
					if (rc_q < count_q) begin
						state_q <= ST_RCHK;
					end else begin
						r_rf_q <= phase_q;
						state_q <= ST_DONE;
					end
				end
				ST_RCHK: begin
					if (map_q[rc_w] && (ro_q < len_cur)) begin
						state_q <= phase_q ? ST_DONE : ST_RDATA;
					end else begin
						rc_q <= rc_q + CW'(1);
						ro_q <= '0;
						state_q <= ST_RLEN;
					end
				end
				ST_RDATA: begin
					r_rv_q <= 1'b1;
					r_rb_q <= store_rdata_s1;
					ro_q <= ro_q + LW'(1);
					phase_q <= 1'b1;
					state_q <= ST_RLEN;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {3'b0, crc_q, points_q, fid_q, r_rb_q, r_rv_q,
							r_mi_q, r_mf_q, bytes_q, all_rcv, set_up_q, r_acc_q};
						m_tlast_q <= r_rf_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

endmodule

/* rtl/fcr_checker.sv */
`include "assert_macros.svh"

module fcr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fcr_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	`ASSERT_SAME(a_final_needs_byte, clk, arst_n, m_tvalid && !m_tdata[28], !m_tlast)
	`ASSERT_SAME(a_found_not_accepted, clk, arst_n, m_tvalid && m_tdata[21], !m_tdata[0])
	`ASSERT_SAME(a_all_needs_frame, clk, arst_n, m_tvalid && m_tdata[2], m_tdata[1])
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ASSERT_NEXT(a_busy_after_request, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind frame_chunk_reassembly fcr_checker u_fcr_checker (.*);
